// ----- hdl/i2c_single_byte_master_defines.svh -----
// Assertion macros shared by the I2C single-byte master RTL.
`ifndef I2C_SINGLE_BYTE_MASTER_DEFINES_SVH
`define I2C_SINGLE_BYTE_MASTER_DEFINES_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Expression never holds.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ----- hdl/i2csb_pkg.sv -----
// Shared types, constants and helpers of the I2C single-byte master.
package i2csb_pkg;

   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;
   localparam int REG_SEL_BIT         = 2;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [15:0] QPT_RESET = 16'd125;
   localparam logic [15:0] ATO_RESET = 16'd255;

   localparam logic REG_QPT = 1'b0;
   localparam logic REG_ATO = 1'b1;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_ST_A,
      PH_ST_B,
      PH_TX_L1,
      PH_TX_L2,
      PH_TX_H1,
      PH_TX_H2,
      PH_AK_L1,
      PH_AK_L2,
      PH_AK_H1,
      PH_AK_H2,
      PH_RX_L1,
      PH_RX_L2,
      PH_RX_H1,
      PH_RX_H2,
      PH_NK_L1,
      PH_NK_L2,
      PH_NK_H1,
      PH_NK_H2,
      PH_SP_L1,
      PH_SP_L2,
      PH_SP_H1,
      PH_SP_H2
   } phase_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] addr_byte;
      logic [7:0] write_data;
      logic       sda_in;
   } pkt_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic       success;
      logic [7:0] read_data;
   } res_type;

   // Plain in-order successor for phases that end without a special action.
   function automatic phase_type phase_succ(input phase_type ph);
      phase_type nxt;
      nxt = PH_IDLE;
      case (ph)
         PH_ST_A:  nxt = PH_ST_B;
         PH_TX_L1: nxt = PH_TX_L2;
         PH_TX_L2: nxt = PH_TX_H1;
         PH_TX_H1: nxt = PH_TX_H2;
         PH_AK_L1: nxt = PH_AK_L2;
         PH_AK_L2: nxt = PH_AK_H1;
         PH_AK_H1: nxt = PH_AK_H2;
         PH_RX_L1: nxt = PH_RX_L2;
         PH_RX_L2: nxt = PH_RX_H1;
         PH_RX_H1: nxt = PH_RX_H2;
         PH_NK_L1: nxt = PH_NK_L2;
         PH_NK_L2: nxt = PH_NK_H1;
         PH_NK_H1: nxt = PH_NK_H2;
         PH_SP_L1: nxt = PH_SP_L2;
         PH_SP_L2: nxt = PH_SP_H1;
         PH_SP_H1: nxt = PH_SP_H2;
         default:  nxt = PH_IDLE;
      endcase
      return nxt;
   endfunction

endpackage

// ----- hdl/i2csb_front.sv -----
// Front stage: accept input items, decode the opcode and hold one item.
module i2csb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        opcode,
   input  logic [7:0]        addr_byte,
   input  logic [7:0]        write_data,
   input  logic              sda_in,
   output logic              out_valid,
   input  logic              out_ready,
   output i2csb_pkg::pkt_type out_pkt
);
   import i2csb_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   pkt_type pkt_ff;
   pkt_type pkt_in;
   logic    take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      pkt_in            = pkt_ff;
      pkt_in.addr_byte  = addr_byte;
      pkt_in.write_data = write_data;
      pkt_in.sda_in     = sda_in;
      // opcode three and anything unknown counts as no command
      case (opcode)
         OP_WRITE: pkt_in.cmd = CMD_WRITE;
         OP_READ:  pkt_in.cmd = CMD_READ;
         default:  pkt_in.cmd = CMD_NONE;
      endcase
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pkt_ff <= pkt_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pkt   = pkt_ff;

endmodule

// ----- hdl/i2csb_queue.sv -----
// Short in-order queue between the front stage and the bus engine.
module i2csb_queue #(
   parameter int DEPTH = i2csb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  i2csb_pkg::pkt_type push_pkt,
   output logic               pop_valid,
   input  logic               pop_ready,
   output i2csb_pkg::pkt_type pop_pkt
);
   import i2csb_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PTR_W = $clog2(DEPTH);

   pkt_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_pkt    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_pkt;
      end
   end

endmodule

// ----- hdl/i2csb_engine.sv -----
// Bus engine: advance the I2C transfer one tick per item and register the result.
`include "i2c_single_byte_master_defines.svh"
module i2csb_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        quarter_period_ticks,
   input  logic [15:0]        ack_timeout_ticks,
   input  logic               in_valid,
   output logic               in_ready,
   input  i2csb_pkg::pkt_type in_pkt,
   output logic               out_valid,
   input  logic               out_ready,
   output i2csb_pkg::res_type out_res
);
   import i2csb_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic [15:0] wait_ff, wait_in;
   logic        is_read_ff, is_read_in;
   logic [7:0]  held_ff, held_in;
   logic        scl_out_ff, scl_out_in;
   logic        sda_out_ff, sda_out_in;
   logic        on_data_ff, on_data_in;
   logic        ok_ff, ok_in;

   logic        out_valid_ff, out_valid_in;
   res_type     res_ff, res_in;

   logic        step;
   logic [15:0] q_eff;
   logic [15:0] lim;
   logic        tick_last;
   logic [15:0] wait_inc;
   logic [3:0]  bit_inc;
   logic        go;
   phase_type   go_phase;
   logic        done;

   assign in_ready  = !out_valid_ff || out_ready;
   assign step      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      q_eff     = (quarter_period_ticks == 16'd0) ? 16'd1 : quarter_period_ticks;
      lim       = (ack_timeout_ticks == 16'd0) ? 16'd1 : ack_timeout_ticks;
      tick_last = ({1'b0, tick_ff} + 17'd1) >= {1'b0, q_eff};
      wait_inc  = (wait_ff != 16'hFFFF) ? wait_ff + 16'd1 : wait_ff;
      bit_inc   = bit_ff + 4'd1;

      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      tx_in      = tx_ff;
      rx_in      = rx_ff;
      wait_in    = wait_ff;
      is_read_in = is_read_ff;
      held_in    = held_ff;
      scl_out_in = scl_out_ff;
      sda_out_in = sda_out_ff;
      on_data_in = on_data_ff;
      ok_in      = ok_ff;
      go         = 1'b0;
      go_phase   = phase_ff;
      done       = 1'b0;

      if (step) begin
         if (phase_ff == PH_IDLE) begin
            if (in_pkt.cmd != CMD_NONE) begin
               tx_in      = in_pkt.addr_byte;
               held_in    = in_pkt.write_data;
               is_read_in = (in_pkt.cmd == CMD_READ);
               rx_in      = 8'd0;
               bit_in     = 4'd0;
               wait_in    = 16'd0;
               on_data_in = 1'b0;
               ok_in      = 1'b0;
               go         = 1'b1;
               go_phase   = PH_ST_A;
            end
         end else if (phase_ff == PH_AK_H2 && tick_last) begin
            // sample ACK every tick once SCL has been high for two phases
            if (!in_pkt.sda_in) begin
               if (on_data_ff) begin
                  ok_in    = 1'b1;
                  go       = 1'b1;
                  go_phase = PH_SP_L1;
               end else if (is_read_ff) begin
                  bit_in   = 4'd0;
                  rx_in    = 8'd0;
                  go       = 1'b1;
                  go_phase = PH_RX_L1;
               end else begin
                  tx_in      = held_ff;
                  bit_in     = 4'd0;
                  on_data_in = 1'b1;
                  go         = 1'b1;
                  go_phase   = PH_TX_L1;
               end
            end else begin
               wait_in = wait_inc;
               if (wait_inc >= lim) begin
                  ok_in    = 1'b0;
                  go       = 1'b1;
                  go_phase = PH_SP_L1;
               end
            end
         end else if (!tick_last) begin
            tick_in = tick_ff + 16'd1;
         end else begin
            case (phase_ff)
               PH_TX_H2: begin
                  tx_in  = {tx_ff[6:0], 1'b0};
                  bit_in = bit_inc;
                  go     = 1'b1;
                  if (bit_inc >= 4'd8) begin
                     wait_in  = 16'd0;
                     go_phase = PH_AK_L1;
                  end else begin
                     go_phase = PH_TX_L1;
                  end
               end
               PH_RX_H2: begin
                  rx_in    = {rx_ff[6:0], in_pkt.sda_in};
                  bit_in   = bit_inc;
                  go       = 1'b1;
                  go_phase = (bit_inc >= 4'd8) ? PH_NK_L1 : PH_RX_L1;
               end
               PH_ST_B: begin
                  bit_in     = 4'd0;
                  on_data_in = 1'b0;
                  go         = 1'b1;
                  go_phase   = PH_TX_L1;
               end
               PH_NK_H2: begin
                  ok_in    = 1'b1;
                  go       = 1'b1;
                  go_phase = PH_SP_L1;
               end
               PH_SP_H2: begin
                  phase_in = PH_IDLE;
                  tick_in  = 16'd0;
                  done     = 1'b1;
               end
               default: begin
                  go       = 1'b1;
                  go_phase = phase_succ(phase_ff);
               end
            endcase
         end
      end

      // enter the new phase: restart its tick count and set the bus levels
      if (go) begin
         phase_in = go_phase;
         tick_in  = 16'd0;
         case (go_phase)
            PH_ST_A: begin
               scl_out_in = 1'b1;
               sda_out_in = 1'b1;
            end
            PH_ST_B:  sda_out_in = 1'b0;
            PH_TX_L1, PH_AK_L1, PH_RX_L1, PH_NK_L1, PH_SP_L1: scl_out_in = 1'b0;
            PH_TX_L2: sda_out_in = tx_in[7];
            PH_AK_L2, PH_RX_L2, PH_NK_L2: sda_out_in = 1'b1;
            PH_SP_L2: sda_out_in = 1'b0;
            PH_TX_H1, PH_AK_H1, PH_RX_H1, PH_NK_H1, PH_SP_H1: scl_out_in = 1'b1;
            PH_SP_H2: sda_out_in = 1'b1;
            default: ;
         endcase
      end

      res_in.scl_level = scl_out_in;
      res_in.sda_level = sda_out_in;
      res_in.busy_res  = (phase_in != PH_IDLE);
      res_in.done_res  = done;
      res_in.success   = done && ok_in;
      res_in.read_data = (done && ok_in && is_read_in) ? rx_in : 8'd0;

      if (step) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= 16'd0;
         bit_ff       <= 4'd0;
         tx_ff        <= 8'd0;
         rx_ff        <= 8'd0;
         wait_ff      <= 16'd0;
         is_read_ff   <= 1'b0;
         held_ff      <= 8'd0;
         scl_out_ff   <= 1'b1;
         sda_out_ff   <= 1'b1;
         on_data_ff   <= 1'b0;
         ok_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         tx_ff        <= tx_in;
         rx_ff        <= rx_in;
         wait_ff      <= wait_in;
         is_read_ff   <= is_read_in;
         held_ff      <= held_in;
         scl_out_ff   <= scl_out_in;
         sda_out_ff   <= sda_out_in;
         on_data_ff   <= on_data_in;
         ok_ff        <= ok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         res_ff <= res_in;
      end
   end

   `ASSERT_IMPLY(a_done_not_busy, clock, reset, out_valid_ff && res_ff.done_res, !res_ff.busy_res, "done item still reports busy")
   `ASSERT_IMPLY(a_flags_only_done, clock, reset, out_valid_ff && !res_ff.done_res, !res_ff.success && res_ff.read_data == 8'd0, "status fields set without done")
   `ASSERT_NEVER(a_scl_sda_apart, clock, reset, step && scl_out_in != scl_out_ff && sda_out_in != sda_out_ff, "SCL and SDA change on the same tick")
   `ASSERT_NEXT(a_hold_without_step, clock, reset, !step, $stable(phase_ff) && $stable(tick_ff), "bus state moved without an item")

endmodule

// ----- hdl/i2c_single_byte_master.sv -----
// Top level of the tick-driven I2C single-byte master with its register port.
// Path: an accepted item passes the front register, the queue and the engine result register.
// Throughput: one item per cycle sustained while rsp_ready stays high; the engine advances the bus one tick per item.
// Reset (synchronous, active high): bus idle with SCL and SDA released, queues empty,
// quarter period 125 ticks and ACK timeout 255 ticks.
module i2c_single_byte_master #(
   parameter int QUEUE_DEPTH = i2csb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items: one timing tick each
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [7:0]                          req_addr_byte,
   input  logic [7:0]                          req_write_data,
   input  logic                                req_sda_in,
   // result items: one per input item
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_scl_level,
   output logic                                rsp_sda_level,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic                                rsp_success,
   output logic [7:0]                          rsp_read_data,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [i2csb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [i2csb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [i2csb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import i2csb_pkg::*;

   logic [15:0] qpt_ff, qpt_in;
   logic [15:0] ato_ff, ato_in;
   logic        csr_wr;

   logic        front_valid;
   logic        front_ready;
   pkt_type     front_pkt;
   logic        queue_valid;
   logic        queue_ready;
   pkt_type     queue_pkt;
   res_type     eng_res;

   // Registers: quarter period at byte address 0, ACK timeout at 4.
   // Only the register select bit is decoded; the low byte-lane bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      qpt_in = qpt_ff;
      ato_in = ato_ff;
      if (csr_wr) begin
         if (csr_paddr[REG_SEL_BIT] == REG_ATO) begin
            ato_in = csr_pwdata[15:0];
         end else begin
            qpt_in = csr_pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qpt_ff <= QPT_RESET;
         ato_ff <= ATO_RESET;
      end else begin
         qpt_ff <= qpt_in;
         ato_ff <= ato_in;
      end
   end

   // Read back the selected register, zero-extended to the bus width.
   always_comb begin
      if (csr_paddr[REG_SEL_BIT] == REG_QPT) begin
         csr_prdata = {{(CSR_DATA_W - 16){1'b0}}, qpt_ff};
      end else begin
         csr_prdata = {{(CSR_DATA_W - 16){1'b0}}, ato_ff};
      end
   end

   // Front: take the item and decode its opcode.
   i2csb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .opcode     (req_opcode),
      .addr_byte  (req_addr_byte),
      .write_data (req_write_data),
      .sda_in     (req_sda_in),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_pkt    (front_pkt)
   );

   // Queue: decouple the front from engine stalls on the result side.
   i2csb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_pkt   (front_pkt),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_pkt    (queue_pkt)
   );

   // Engine: advance the bus one tick per item and hold the result until taken.
   i2csb_engine u_engine (
      .clock                (clock),
      .reset                (reset),
      .quarter_period_ticks (qpt_ff),
      .ack_timeout_ticks    (ato_ff),
      .in_valid             (queue_valid),
      .in_ready             (queue_ready),
      .in_pkt               (queue_pkt),
      .out_valid            (rsp_valid),
      .out_ready            (rsp_ready),
      .out_res              (eng_res)
   );

   assign rsp_scl_level = eng_res.scl_level;
   assign rsp_sda_level = eng_res.sda_level;
   assign rsp_busy_res  = eng_res.busy_res;
   assign rsp_done_res  = eng_res.done_res;
   assign rsp_success   = eng_res.success;
   assign rsp_read_data = eng_res.read_data;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the tick-driven I2C single-byte master.
module testbench;
   import i2csb_pkg::*;

   // Opcode three carries no command; name it so the stimulus reads clearly.
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         LIMIT_CYCLES = 600000;
   localparam int         MAX_PRINTED  = 40;

   // ------------------------------------------------------------------
   // Clock, reset and DUT ports; every input starts at a known value.
   // ------------------------------------------------------------------
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_opcode     = OP_NONE;
   logic [7:0]            req_addr_byte  = 8'h00;
   logic [7:0]            req_write_data = 8'h00;
   logic                  req_sda_in     = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic                  rsp_scl_level;
   logic                  rsp_sda_level;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic                  rsp_success;
   logic [7:0]            rsp_read_data;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   i2c_single_byte_master i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_addr_byte  (req_addr_byte),
      .req_write_data (req_write_data),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_success    (rsp_success),
      .rsp_read_data  (rsp_read_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Bookkeeping shared by the sender, the checker and the tests.
   // ------------------------------------------------------------------
   int      err_count  = 0;
   int      cycle_count = 0;
   int      tick_total = 0;   // items accepted so far
   int      rsp_seen   = 0;   // results accepted so far
   int      pause_at   = -1;  // item index at which the sender drains once
   bit      send_pace  = 1'b1;
   bit      recv_pace  = 1'b1;
   res_type bus_levels_q[$];  // expected bus levels and status, oldest first

   // Slave behavior knobs: how SDA answers in the ACK window and elsewhere.
   bit         ack_addr       = 1'b1;
   bit         ack_data       = 1'b1;
   int         ack_delay      = 0;
   int         noise_pct      = 0;
   bit         sda_force_en   = 1'b0;
   bit         sda_force_val  = 1'b1;
   bit         busy_op_random = 1'b0;
   logic [1:0] busy_opcode    = OP_NONE;

   // ------------------------------------------------------------------
   // Bus engine predictor: own copy of the configuration and state.
   // ------------------------------------------------------------------
   logic [15:0] qpt_cfg    = QPT_RESET;
   logic [15:0] ato_cfg    = ATO_RESET;
   phase_type   bus_ph     = PH_IDLE;
   logic [15:0] bus_tick   = '0;
   logic [15:0] ack_wait   = '0;
   logic [3:0]  bit_idx    = '0;
   logic [7:0]  tx_byte    = '0;
   logic [7:0]  rx_byte    = '0;
   logic [7:0]  held_byte  = '0;
   bit          read_xfer  = 1'b0;
   bit          data_stage = 1'b0;  // data byte of a write is on the bus
   bit          xfer_ok    = 1'b0;
   bit          scl_q      = 1'b1;
   bit          sda_q      = 1'b1;

   // A zero quarter period acts as one tick.
   function automatic int quarter_eff();
      return (qpt_cfg == 16'd0) ? 1 : int'(qpt_cfg);
   endfunction

   // Enter a phase: restart the tick counter and drive the levels of its start.
   function automatic void enter_phase(input phase_type p);
      bus_ph   = p;
      bus_tick = '0;
      case (p)
         PH_ST_A: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
         end
         PH_ST_B:                                          sda_q = 1'b0;
         PH_TX_L1, PH_AK_L1, PH_RX_L1, PH_NK_L1, PH_SP_L1: scl_q = 1'b0;
         PH_TX_L2:                                         sda_q = tx_byte[7];
         PH_AK_L2, PH_RX_L2, PH_NK_L2:                     sda_q = 1'b1;
         PH_SP_L2:                                         sda_q = 1'b0;
         PH_TX_H1, PH_AK_H1, PH_RX_H1, PH_NK_H1, PH_SP_H1: scl_q = 1'b1;
         PH_SP_H2:                                         sda_q = 1'b1;
         default: ;
      endcase
   endfunction

   // Close out a timed phase; return 1 when the STOP has just completed.
   function automatic bit end_of_phase(input bit sda);
      case (bus_ph)
         PH_TX_H2: begin
            tx_byte = tx_byte << 1;
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= 4'd8) begin
               ack_wait = '0;
               enter_phase(PH_AK_L1);
            end else begin
               enter_phase(PH_TX_L1);
            end
         end
         PH_RX_H2: begin
            rx_byte = {rx_byte[6:0], sda};
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= 4'd8) enter_phase(PH_NK_L1);
            else enter_phase(PH_RX_L1);
         end
         PH_ST_B: begin
            bit_idx    = '0;
            data_stage = 1'b0;
            enter_phase(PH_TX_L1);
         end
         PH_NK_H2: begin
            xfer_ok = 1'b1;
            enter_phase(PH_SP_L1);
         end
         PH_SP_H2: begin
            bus_ph   = PH_IDLE;
            bus_tick = '0;
            return 1'b1;
         end
         default: enter_phase(phase_type'(bus_ph + 5'd1));
      endcase
      return 1'b0;
   endfunction

   // One tick of the ACK window: low is ACK, high counts toward the timeout.
   function automatic void slave_ack(input bit sda);
      int lim;
      lim = (ato_cfg == 16'd0) ? 1 : int'(ato_cfg);
      if (!sda) begin
         if (data_stage) begin
            xfer_ok = 1'b1;
            enter_phase(PH_SP_L1);
         end else if (read_xfer) begin
            bit_idx = '0;
            rx_byte = '0;
            enter_phase(PH_RX_L1);
         end else begin
            tx_byte    = held_byte;
            bit_idx    = '0;
            data_stage = 1'b1;
            enter_phase(PH_TX_L1);
         end
      end else begin
         if (ack_wait != 16'hFFFF) ack_wait = ack_wait + 16'd1;
         if (int'(ack_wait) >= lim) begin
            xfer_ok = 1'b0;
            enter_phase(PH_SP_L1);
         end
      end
   endfunction

   // Advance the predictor by one item and return the bus levels it yields.
   function automatic res_type step_bus_model(input logic [1:0] op, input logic [7:0] addr,
                                              input logic [7:0] wdata, input bit sda);
      res_type r;
      bit      fin;
      fin = 1'b0;
      if (bus_ph == PH_IDLE) begin
         if (op == OP_WRITE || op == OP_READ) begin
            tx_byte    = addr;
            held_byte  = wdata;
            read_xfer  = (op == OP_READ);
            rx_byte    = '0;
            bit_idx    = '0;
            ack_wait   = '0;
            data_stage = 1'b0;
            xfer_ok    = 1'b0;
            enter_phase(PH_ST_A);
         end
      end else if (bus_ph == PH_AK_H2 && int'(bus_tick) + 1 >= quarter_eff()) begin
         slave_ack(sda);
      end else if (int'(bus_tick) + 1 < quarter_eff()) begin
         bus_tick = bus_tick + 16'd1;
      end else begin
         fin = end_of_phase(sda);
      end
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.busy_res  = (bus_ph != PH_IDLE);
      r.done_res  = fin;
      r.success   = fin && xfer_ok;
      r.read_data = (fin && xfer_ok && read_xfer) ? rx_byte : 8'h00;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   function automatic int idle_cycles(input bit paced);
      return paced ? int'($urandom_range(0, 11)) : 0;
   endfunction

   // Pick the SDA level the slave shows on the next tick.
   function automatic bit pick_sda();
      bit want;
      if (noise_pct > 0 && int'($urandom_range(0, 99)) < noise_pct) return 1'($urandom);
      if (bus_ph == PH_AK_H2 && int'(bus_tick) + 1 >= quarter_eff()) begin
         want = data_stage ? ack_data : ack_addr;
         // ACK once the wanted number of high ticks has passed
         return (want && int'(ack_wait) >= ack_delay) ? 1'b0 : 1'b1;
      end
      if (sda_force_en) return sda_force_val;
      return 1'($urandom);
   endfunction

   function automatic logic [1:0] busy_op();
      return busy_op_random ? 2'($urandom_range(0, 3)) : busy_opcode;
   endfunction

   task automatic report_error(input string msg);
      err_count++;
      if (err_count <= MAX_PRINTED) $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   // Drop valid and hold until every expected result has come back.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (bus_levels_q.size() != 0);
   endtask

   // Send one item: idle for a drawn gap, present it, hold until accepted.
   task automatic send_item(input logic [1:0] op, input logic [7:0] addr,
                            input logic [7:0] wdata, input bit sda);
      int gap;
      if (tick_total == pause_at) wait_all_results();
      gap = idle_cycles(send_pace);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_addr_byte  <= addr;
      req_write_data <= wdata;
      req_sda_in     <= sda;
      do @(posedge clock); while (!req_ready);
      bus_levels_q.push_back(step_bus_model(op, addr, wdata, sda));
      tick_total++;
   endtask

   // Issue a command from idle and tick until the bus is idle again.
   task automatic run_transfer(input logic [1:0] op, input logic [7:0] addr,
                               input logic [7:0] wdata, input bit ack_a, input bit ack_d,
                               input int delay);
      ack_addr  = ack_a;
      ack_data  = ack_d;
      ack_delay = delay;
      send_item(op, addr, wdata, pick_sda());
      while (bus_ph != PH_IDLE) send_item(busy_op(), 8'($urandom), 8'($urandom), pick_sda());
   endtask

   task automatic idle_ticks(input int n);
      repeat (n) begin
         send_item($urandom_range(0, 1) ? OP_NONE : OP_UNUSED, 8'($urandom), 8'($urandom),
                   1'($urandom));
      end
   endtask

   // Register port: setup cycle, then access cycle; the write lands at its edge.
   task automatic csr_write(input logic idx, input logic [15:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << REG_SEL_BIT;
      csr_pwdata  <= {16'($urandom), val};   // upper bits must be ignored
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == REG_QPT) qpt_cfg = val;
      else ato_cfg = val;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic idx, input logic [15:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx) << REG_SEL_BIT;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[15:0] !== want)
         report_error($sformatf("register %0d reads %h, expected %h", idx, csr_prdata[15:0],
                                want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Change timing only with the bus idle and nothing outstanding.
   task automatic set_timing(input logic [15:0] qpt, input logic [15:0] ato);
      wait_all_results();
      csr_write(REG_QPT, qpt);
      csr_write(REG_ATO, ato);
      csr_check(REG_QPT, qpt);
      csr_check(REG_ATO, ato);
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------
   // Registers come out of reset at their defaults; the idle bus stays
   // released, and opcode three is no command.
   task automatic test_register_reset();
      csr_check(REG_QPT, QPT_RESET);
      csr_check(REG_ATO, ATO_RESET);
      send_item(OP_NONE, 8'hFF, 8'hFF, 1'b0);
      send_item(OP_UNUSED, 8'h00, 8'h00, 1'b1);
      send_item(OP_UNUSED, 8'hFF, 8'h00, 1'b0);
   endtask

   // Writes with both ACKs, extreme address and data bytes, and a late ACK.
   task automatic test_write_transfers();
      set_timing(16'd1, 16'd4);
      run_transfer(OP_WRITE, 8'h00, 8'hFF, 1'b1, 1'b1, 0);
      run_transfer(OP_WRITE, 8'hFF, 8'h00, 1'b1, 1'b1, 3);
      set_timing(16'd2, 16'd6);
      run_transfer(OP_WRITE, 8'hA4, 8'h5B, 1'b1, 1'b1, 1);
   endtask

   // Reads of all ones, all zeros and a random byte.
   task automatic test_read_transfers();
      set_timing(16'd1, 16'd5);
      sda_force_en  = 1'b1;
      sda_force_val = 1'b1;
      run_transfer(OP_READ, 8'hFF, 8'h00, 1'b1, 1'b1, 0);
      sda_force_val = 1'b0;
      run_transfer(OP_READ, 8'h01, 8'hFF, 1'b1, 1'b1, 2);
      sda_force_en  = 1'b0;
      run_transfer(OP_READ, 8'h81, 8'h3C, 1'b1, 1'b1, 0);
   endtask

   // NACK on the address, NACK on the data, and ACK right at the timeout.
   task automatic test_nack_paths();
      set_timing(16'd1, 16'd3);
      run_transfer(OP_WRITE, 8'h50, 8'h11, 1'b0, 1'b1, 0);
      run_transfer(OP_WRITE, 8'h50, 8'h22, 1'b1, 1'b0, 0);
      run_transfer(OP_READ,  8'h51, 8'h00, 1'b0, 1'b1, 0);
      run_transfer(OP_WRITE, 8'h52, 8'h33, 1'b1, 1'b1, 3);   // ACK too late
      run_transfer(OP_WRITE, 8'h52, 8'h44, 1'b1, 1'b1, 2);   // last tick in time
   endtask

   // Commands while busy are ignored, the done tick included; run with no
   // idling on either side and transfers back to back.
   task automatic test_busy_commands();
      set_timing(16'd1, 16'd2);
      send_pace   = 1'b0;
      recv_pace   = 1'b0;
      busy_opcode = OP_READ;
      run_transfer(OP_WRITE, 8'h3A, 8'hC5, 1'b1, 1'b1, 0);
      busy_opcode = OP_WRITE;
      run_transfer(OP_READ, 8'h3B, 8'h00, 1'b1, 1'b1, 0);
      run_transfer(OP_WRITE, 8'h3C, 8'h96, 1'b1, 1'b0, 0);
      busy_opcode = OP_NONE;
      send_pace   = 1'b1;
      recv_pace   = 1'b1;
   endtask

   // Zero quarter period and zero timeout behave as one tick.
   task automatic test_zero_registers();
      set_timing(16'd0, 16'd0);
      run_transfer(OP_WRITE, 8'h7E, 8'h81, 1'b1, 1'b1, 0);
      run_transfer(OP_READ,  8'h7F, 8'h00, 1'b0, 1'b1, 0);
   endtask

   // Largest register values: idle ticks at the longest quarter period,
   // slow ACKs under the longest timeout.
   task automatic test_register_extremes();
      set_timing(16'hFFFF, 16'd1);
      idle_ticks(6);
      set_timing(16'd1, 16'hFFFF);
      run_transfer(OP_WRITE, 8'hC0, 8'hEE, 1'b1, 1'b1, 30);
      run_transfer(OP_READ,  8'hC1, 8'h00, 1'b1, 1'b1, 12);
   endtask

   // Mostly well-formed transfers with random content, random timing
   // settings, commands and noise thrown at the busy bus.
   task automatic test_random_traffic();
      int         stop_at;
      int         lim;
      bit         nack_ok;
      logic [1:0] op;
      busy_op_random = 1'b1;
      noise_pct      = 8;
      for (int s = 0; s < 6; s++) begin
         case (s)
            0:       set_timing(16'd1, 16'd1);
            1:       set_timing(16'd1, 16'd8);
            2:       set_timing(16'd2, 16'd3);
            3:       set_timing(16'd3, 16'hFFFF);
            4:       set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 12)));
            default: set_timing(16'd1, 16'd2);
         endcase
         lim      = (ato_cfg == 16'd0) ? 1 : int'(ato_cfg);
         nack_ok  = (lim <= 255);   // a NACK under a huge timeout takes too long
         pause_at = tick_total + int'($urandom_range(5, 35));
         stop_at  = tick_total + 40;
         while (tick_total < stop_at) begin
            send_pace = ($urandom_range(0, 3) != 0);
            recv_pace = ($urandom_range(0, 3) != 0);
            idle_ticks($urandom_range(0, 3));
            op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
            run_transfer(op, 8'($urandom), 8'($urandom),
                         !nack_ok || $urandom_range(0, 99) >= 15,
                         !nack_ok || $urandom_range(0, 99) >= 15,
                         $urandom_range(0, (lim > 10) ? 10 : lim));
         end
      end
      busy_op_random = 1'b0;
      noise_pct      = 0;
      send_pace      = 1'b1;
      recv_pace      = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Result side: stall at random, check each result against the oldest
   // expectation.
   // ------------------------------------------------------------------
   int hold_left = 0;

   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (rsp_ready && rsp_valid) begin
         // result taken: draw the stall before the next one
         stall = idle_cycles(recv_pace);
         if (stall == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            hold_left <= stall;
         end
      end else if (!rsp_ready) begin
         if (hold_left <= 1) rsp_ready <= 1'b1;
         if (hold_left > 0) hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (bus_levels_q.size() == 0) begin
            report_error($sformatf("result %0d arrived with nothing expected", rsp_seen));
         end else begin
            want = bus_levels_q.pop_front();
            if (rsp_scl_level !== want.scl_level)
               report_error($sformatf("result %0d scl_level %b, expected %b", rsp_seen,
                                      rsp_scl_level, want.scl_level));
            if (rsp_sda_level !== want.sda_level)
               report_error($sformatf("result %0d sda_level %b, expected %b", rsp_seen,
                                      rsp_sda_level, want.sda_level));
            if (rsp_busy_res !== want.busy_res)
               report_error($sformatf("result %0d busy_res %b, expected %b", rsp_seen,
                                      rsp_busy_res, want.busy_res));
            if (rsp_done_res !== want.done_res)
               report_error($sformatf("result %0d done_res %b, expected %b", rsp_seen,
                                      rsp_done_res, want.done_res));
            if (rsp_success !== want.success)
               report_error($sformatf("result %0d success %b, expected %b", rsp_seen,
                                      rsp_success, want.success));
            if (rsp_read_data !== want.read_data)
               report_error($sformatf("result %0d read_data %h, expected %h", rsp_seen,
                                      rsp_read_data, want.read_data));
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if it hangs.
   // ------------------------------------------------------------------
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("timeout after %0d cycles", cycle_count);
      $display("i2c_single_byte_master regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      // hold reset at the start, then drop it once for good
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_register_reset();
      test_write_transfers();
      test_read_transfers();
      test_nack_paths();
      test_busy_commands();
      test_zero_registers();
      test_register_extremes();
      test_random_traffic();
      // drain, then let the result pipeline settle
      wait_all_results();
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("i2c_single_byte_master regression: pass");
      end else begin
         $display("i2c_single_byte_master regression: fail");
      end
      $finish;
   end

endmodule
